// File: rtl/epdm_pkg.sv
// Shared types and constants of the energy pulse demand meter.
package epdm_pkg;

  // Depth of the minute ring (one slot per minute of the demand window).
  localparam int unsigned HISTORY_DEPTH = 30;
  localparam int unsigned PTR_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned ENERGY_W = 48;
  localparam int unsigned SUM_W    = 49;
  localparam int unsigned FREQ_W   = 20;
  localparam int unsigned POWER_W  = 56;
  localparam int unsigned CFG_IDX_W = 2;

  // Dividend of the frequency division: one million milli-hertz per millisecond.
  localparam logic [FREQ_W-1:0] FREQ_NUMERATOR = FREQ_W'(1000000);

  // Input stream item kinds.
  localparam logic OP_PIN  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COEFFICIENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH   = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] COEFFICIENT_RESET = CFG_W'(12);
  localparam logic [CFG_W-1:0] MIN_WIDTH_RESET   = CFG_W'(10);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FREQ,
    ST_ENERGY,
    ST_TICK,
    ST_READ,
    ST_POWER,
    ST_FORE1,
    ST_FORE2,
    ST_OUT
  } epdm_state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_PIN,
    DP_FREQ,
    DP_ENERGY,
    DP_TICK,
    DP_READ,
    DP_POWER,
    DP_FORE1,
    DP_FORE2,
    DP_OUT
  } epdm_op_e;

  typedef struct packed {
    epdm_op_e op;
    logic     div_start;
  } epdm_cmd_t;

  typedef struct packed {
    logic op_tick;
    logic need_div;
    logic div_busy;
    logic half_phase;
    logic out_free;
  } epdm_stat_t;

endpackage

// File: rtl/energy_pulse_demand_meter_top.sv
// Top level of the energy pulse counter with a 30-minute demand window.
//
//   Channel  Direction  Transfer content
//   s_axis   in         tuser: operation; tdata: pin_level, time_ms
//   m_axis   out        tdata: pulse_total, energy, frequency_mhz, demand_now,
//                       demand_forecast, pulse_accepted, pulse_too_short
//   cfg      in         cfg_index_i selects coefficient (0) or min_width_ms (1)
//
// One item is handled at a time. A pin sample is evaluated and updates the energy;
// a counted pulse may first start the bit-serial frequency division and wait for
// it. A demand tick also runs the tick step; the second tick of a pair writes the
// minute ring, reads back its oldest slot and computes demand and forecast.
// The result sits in an output register, so the next input transfer is taken
// in the cycle after the result is loaded, while it waits; the controller only stalls
// when a second result is ready before the first one is taken. Reset clears all
// control state and the ring valid bits at once, so no clearing pass is needed.
// Configuration is always ready; writes to an unused index are ignored.
module energy_pulse_demand_meter_top
  import epdm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input items.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Bit 0 pin_level, bits 32:1 time_ms, rest zero.
  input  logic [39:0]          s_axis_tdata,
  // Bit 0 operation.
  input  logic [0:0]           s_axis_tuser,
  // Result items.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Bits 31:0 pulse_total, 79:32 energy, 99:80 frequency_mhz,
  // 155:100 demand_now, 211:156 demand_forecast, 212 pulse_accepted,
  // 213 pulse_too_short, rest zero.
  output logic [215:0]         m_axis_tdata,
  // Configuration writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  epdm_cmd_t  cmd;
  epdm_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // The controller only sequences; all arithmetic and storage sit in the datapath.
  epdm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  epdm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_op_i    (s_axis_tuser[0]),
    .in_level_i (s_axis_tdata[0]),
    .in_time_i  (s_axis_tdata[32:1]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata)
  );

endmodule

// File: rtl/epdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module epdm_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/epdm_div.sv
// Bit-serial restoring divider for the pulse frequency: one quotient bit per cycle.
module epdm_div
  import epdm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] divisor_i,
  output logic              busy_o,
  output logic [FREQ_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(FREQ_W);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] dvs_q, dvs_d;
  logic [FREQ_W-1:0] num_q, num_d;
  logic [FREQ_W-1:0] rem_q, rem_d;
  logic [FREQ_W-1:0] quo_q, quo_d;
  logic [FREQ_W:0]   trial;
  logic              fits;

  // The partial remainder never reaches 2^20, so a 21-bit trial value suffices.
  assign trial = {rem_q, num_q[FREQ_W-1]};
  assign fits  = {{(TIME_W-FREQ_W-1){1'b0}}, trial} >= dvs_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvs_d  = divisor_i;
      num_d  = FREQ_NUMERATOR;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[FREQ_W-2:0], 1'b0};
      quo_d = {quo_q[FREQ_W-2:0], fits};
      if (fits) begin
        rem_d = FREQ_W'(trial - dvs_q[FREQ_W:0]);
      end else begin
        rem_d = FREQ_W'(trial);
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(FREQ_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/epdm_dp.sv
// Datapath of the meter: pulse state, energy, demand ring, power and output register.
module epdm_dp
  import epdm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  epdm_cmd_t            cmd_i,
  output epdm_stat_t           stat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_op_i,
  input  logic                 in_level_i,
  input  logic [TIME_W-1:0]    in_time_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [215:0]         out_data_o
);

  logic [CFG_W-1:0]    coef_q, minw_q;
  logic                op_q, level_q;
  logic [TIME_W-1:0]   time_q;
  logic                prev_q, stamp_vld_q, acc_flag_q, short_flag_q;
  logic [TIME_W-1:0]   rise_q, stamp_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic [FREQ_W-1:0]   freq_q;
  logic [ENERGY_W-1:0] energy_q;
  logic                phase_q;
  logic [SUM_W-1:0]    half_q, newest_q;
  logic [PTR_W-1:0]    ptr_q;
  logic [HISTORY_DEPTH-1:0] ring_vld_q;
  logic                rd_vld_q;
  logic [POWER_W-1:0]  acc_q, pnow_q, pfore_q;
  logic                out_valid_q;
  logic [215:0]        out_data_q;

  logic                rise, fall, long_enough;
  logic [TIME_W-1:0]   width, interval;
  logic [SUM_W-1:0]    sum;
  logic [PTR_W-1:0]    ptr_next;
  logic [SUM_W-1:0]    ring_rdata;
  logic [POWER_W-1:0]  e56, old56, new56;
  logic                ring_we, ring_re;
  logic [FREQ_W-1:0]   quotient;
  logic                div_busy;

  assign rise        = !prev_q && level_q;
  assign fall        = prev_q && !level_q;
  assign width       = time_q - rise_q;
  assign long_enough = width >= {{(TIME_W-CFG_W){1'b0}}, minw_q};
  assign interval    = time_q - stamp_q;

  assign sum      = half_q + {1'b0, energy_q};
  assign ptr_next = (ptr_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);

  assign e56   = {{(POWER_W-ENERGY_W){1'b0}}, energy_q};
  assign old56 = rd_vld_q ? {{(POWER_W-SUM_W){1'b0}}, ring_rdata} : '0;
  assign new56 = {{(POWER_W-SUM_W){1'b0}}, newest_q};

  assign ring_we = (cmd_i.op == DP_TICK) && phase_q;
  assign ring_re = (cmd_i.op == DP_READ);

  assign stat_o.op_tick    = (op_q == OP_TICK);
  assign stat_o.need_div   = (op_q == OP_PIN) && fall && long_enough && stamp_vld_q
                             && (interval != '0);
  assign stat_o.div_busy   = div_busy;
  assign stat_o.half_phase = phase_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  epdm_ram #(
    .WIDTH (SUM_W),
    .DEPTH (HISTORY_DEPTH),
    .ADDR_W(PTR_W)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ptr_q),
    .wdata_i(sum),
    .re_i   (ring_re),
    .raddr_i(ptr_q),
    .rdata_o(ring_rdata)
  );

  epdm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .divisor_i (interval),
    .busy_o    (div_busy),
    .quotient_o(quotient)
  );

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEFFICIENT_RESET;
      minw_q <= MIN_WIDTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COEFFICIENT: coef_q <= cfg_data_i;
        CFG_MIN_WIDTH:   minw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Meter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= 1'b0;
      rise_q       <= '0;
      cnt_q        <= '0;
      stamp_q      <= '0;
      stamp_vld_q  <= 1'b0;
      freq_q       <= '0;
      energy_q     <= '0;
      phase_q      <= 1'b0;
      half_q       <= '0;
      ptr_q        <= '0;
      ring_vld_q   <= '0;
      pnow_q       <= '0;
      pfore_q      <= '0;
      acc_flag_q   <= 1'b0;
      short_flag_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        DP_LOAD: begin
          acc_flag_q   <= 1'b0;
          short_flag_q <= 1'b0;
        end
        DP_PIN: begin
          if (op_q == OP_PIN) begin
            prev_q <= level_q;
            if (rise) begin
              rise_q <= time_q;
            end
            if (fall && long_enough) begin
              cnt_q       <= cnt_q + COUNT_W'(1);
              acc_flag_q  <= 1'b1;
              stamp_q     <= time_q;
              stamp_vld_q <= 1'b1;
            end
            if (fall && !long_enough) begin
              short_flag_q <= 1'b1;
            end
          end
        end
        DP_FREQ:   freq_q   <= quotient;
        DP_ENERGY: energy_q <= {{(ENERGY_W-COUNT_W){1'b0}}, cnt_q}
                               * {{(ENERGY_W-CFG_W){1'b0}}, coef_q};
        DP_TICK: begin
          if (!phase_q) begin
            half_q  <= sum;
            phase_q <= 1'b1;
          end else begin
            half_q            <= '0;
            phase_q           <= 1'b0;
            ring_vld_q[ptr_q] <= 1'b1;
            ptr_q             <= ptr_next;
          end
        end
        DP_POWER: pnow_q  <= {e56[POWER_W-2:0], 1'b0} - old56;
        DP_FORE2: pfore_q <= acc_q + {new56[POWER_W-2:0], 1'b0};
        default: ;
      endcase
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        op_q    <= in_op_i;
        level_q <= in_level_i;
        time_q  <= in_time_i;
      end
      DP_TICK: begin
        if (phase_q) begin
          newest_q <= sum;
        end
      end
      DP_READ: begin
        rd_vld_q <= ring_vld_q[ptr_q];
        acc_q    <= {e56[POWER_W-7:0], 6'b0} - {e56[POWER_W-2:0], 1'b0};
      end
      DP_POWER: acc_q <= acc_q - old56;
      DP_FORE1: acc_q <= acc_q - {new56[POWER_W-6:0], 5'b0};
      DP_OUT: begin
        out_data_q <= {2'b00, short_flag_q, acc_flag_q, pfore_q, pnow_q, freq_q, energy_q,
                       cnt_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/epdm_ctrl.sv
// Controller state machine that sequences the meter datapath for each item.
module epdm_ctrl
  import epdm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  epdm_stat_t stat_i,
  output epdm_cmd_t  cmd_o
);

  epdm_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:   state_d = stat_i.need_div ? ST_DIV : ST_ENERGY;
      ST_DIV:    if (!stat_i.div_busy) state_d = ST_FREQ;
      ST_FREQ:   state_d = ST_ENERGY;
      ST_ENERGY: state_d = stat_i.op_tick ? ST_TICK : ST_OUT;
      ST_TICK:   state_d = stat_i.half_phase ? ST_READ : ST_OUT;
      ST_READ:   state_d = ST_POWER;
      ST_POWER:  state_d = ST_FORE1;
      ST_FORE1:  state_d = ST_FORE2;
      ST_FORE2:  state_d = ST_OUT;
      ST_OUT:    if (stat_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.op        = DP_NOP;
    cmd_o.div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = DP_LOAD;
      end
      ST_EVAL: begin
        cmd_o.op        = DP_PIN;
        cmd_o.div_start = stat_i.need_div;
      end
      ST_DIV:    cmd_o.op = DP_NOP;
      ST_FREQ:   cmd_o.op = DP_FREQ;
      ST_ENERGY: cmd_o.op = DP_ENERGY;
      ST_TICK:   cmd_o.op = DP_TICK;
      ST_READ:   cmd_o.op = DP_READ;
      ST_POWER:  cmd_o.op = DP_POWER;
      ST_FORE1:  cmd_o.op = DP_FORE1;
      ST_FORE2:  cmd_o.op = DP_FORE2;
      ST_OUT:    if (stat_i.out_free) cmd_o.op = DP_OUT;
      default:   cmd_o.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
